// File: hdl/jib_pkg.sv
// package of the integer bytecode unit: opcodes, codes, command structs and helpers
package jib_pkg;

  // default sizes of the operand stack and the local-variable file
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned LOCAL_COUNT_DEF = 16;

  // payload widths
  localparam int unsigned FUNC_W    = 8;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned IMM_W     = 8;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned PC_W      = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CMP_W     = 3;

  // opcode bytes, standard numbering
  localparam logic [FUNC_W-1:0] OP_ICONST_NEG = 8'h02;
  localparam logic [FUNC_W-1:0] OP_ICONST_5   = 8'h08;
  localparam logic [FUNC_W-1:0] OP_BIPUSH     = 8'h10;
  localparam logic [FUNC_W-1:0] OP_ILOAD_0    = 8'h1a;
  localparam logic [FUNC_W-1:0] OP_ILOAD_3    = 8'h1d;
  localparam logic [FUNC_W-1:0] OP_ISTORE_0   = 8'h3b;
  localparam logic [FUNC_W-1:0] OP_ISTORE_3   = 8'h3e;
  localparam logic [FUNC_W-1:0] OP_IADD       = 8'h60;
  localparam logic [FUNC_W-1:0] OP_ISUB       = 8'h64;
  localparam logic [FUNC_W-1:0] OP_IMUL       = 8'h68;
  localparam logic [FUNC_W-1:0] OP_ISHL       = 8'h78;
  localparam logic [FUNC_W-1:0] OP_ISHR       = 8'h7a;
  localparam logic [FUNC_W-1:0] OP_IINC       = 8'h84;
  localparam logic [FUNC_W-1:0] OP_IFEQ       = 8'h99;
  localparam logic [FUNC_W-1:0] OP_IFGE       = 8'h9c;
  localparam logic [FUNC_W-1:0] OP_IFLE       = 8'h9e;
  localparam logic [FUNC_W-1:0] OP_IF_ICMPEQ  = 8'h9f;
  localparam logic [FUNC_W-1:0] OP_IF_ICMPLT  = 8'ha1;
  localparam logic [FUNC_W-1:0] OP_IF_ICMPLE  = 8'ha4;
  localparam logic [FUNC_W-1:0] OP_GOTO       = 8'ha7;
  localparam logic [FUNC_W-1:0] OP_IRETURN    = 8'hac;
  localparam logic [FUNC_W-1:0] OP_RETURN     = 8'hb1;
  localparam logic [FUNC_W-1:0] OP_GETSTATIC  = 8'hb2;

  // instruction lengths in bytes
  localparam logic [PC_W-1:0] LEN_SHORT  = 16'd1;
  localparam logic [PC_W-1:0] LEN_BYTE   = 16'd2;
  localparam logic [PC_W-1:0] LEN_WIDE   = 16'd3;

  // the first constant opcode pushes -1, so the pushed value is the opcode less this bias
  localparam logic [WORD_W-1:0] ICONST_BIAS = 32'd3;

  // comparison kinds, in opcode order
  localparam logic [CMP_W-1:0] CMP_EQ = 3'd0;
  localparam logic [CMP_W-1:0] CMP_NE = 3'd1;
  localparam logic [CMP_W-1:0] CMP_LT = 3'd2;
  localparam logic [CMP_W-1:0] CMP_GE = 3'd3;
  localparam logic [CMP_W-1:0] CMP_GT = 3'd4;
  localparam logic [CMP_W-1:0] CMP_LE = 3'd5;

  // result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_LOCAL = 2'd3
  } status_e;

  // stack movement of one instruction
  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_PUSH,
    SOP_POP1,
    SOP_POP2_PUSH1,
    SOP_POP2
  } stk_op_e;

  typedef struct packed {
    stk_op_e             op;
    logic [WORD_W-1:0]   value;
  } stk_cmd_t;

  typedef struct packed {
    logic                en;
    logic [INDEX_W-1:0]  addr;
    logic [WORD_W-1:0]   data;
  } lv_wr_t;

  typedef struct packed {
    logic [PC_W-1:0]     next_pc;
    logic                branch_taken;
    logic                halted;
    status_e             status;
  } exec_res_t;

  // signed compare of two words
  function automatic logic cmp_f(input logic [CMP_W-1:0] kind,
                                 input logic signed [WORD_W-1:0] a,
                                 input logic signed [WORD_W-1:0] b);
    logic r;
    case (kind)
      CMP_EQ:  r = (a == b);
      CMP_NE:  r = (a != b);
      CMP_LT:  r = (a < b);
      CMP_GE:  r = (a >= b);
      CMP_GT:  r = (a > b);
      CMP_LE:  r = (a <= b);
      default: r = (a <= b);
    endcase
    return r;
  endfunction

endpackage

// File: hdl/jib_in_if.sv
// request channel carrying one bytecode and its operands
interface jib_in_if import jib_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [INDEX_W-1:0]         local_index;
  logic signed [IMM_W-1:0]    immediate;
  logic signed [OFFSET_W-1:0] branch_offset;
  logic [PC_W-1:0]            pc;

  modport source (output valid, func, local_index, immediate, branch_offset, pc,
                  input ready);
  modport sink   (input valid, func, local_index, immediate, branch_offset, pc,
                  output ready);
endinterface

// File: hdl/jib_out_if.sv
// result channel carrying the outcome of one bytecode
interface jib_out_if import jib_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic                     branch_taken;
  logic                     halted;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] top_value;
  logic [COUNT_W-1:0]       stack_count;

  modport source (output valid, next_pc, branch_taken, halted, status, top_value,
                  stack_count, input ready);
  modport sink   (input valid, next_pc, branch_taken, halted, status, top_value,
                  stack_count, output ready);
endinterface

// File: hdl/jvm_integer_bytecode_unit.sv
// top level of the integer bytecode unit: input register, execute, result register
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-------------------------------------------------
//  in_i    | in  | valid / ready  | func, local_index, immediate, branch_offset, pc
//  out_o   | out | valid / ready  | next_pc, branch_taken, halted, status,
//          |     |                | top_value, stack_count
//
// one bytecode a cycle while the result side is not stalled; a result is offered once
// its request has passed both registers (the request lands in the input register with
// the local-file ram read, then execute fills the result register).
// reset empties the operand stack and zeroes the locals through per-entry valid bits,
// so requests are taken from the first cycle after reset.
// a stalled result holds the result register; the input register then holds too and
// in_i.ready falls only when both are full.
module jvm_integer_bytecode_unit import jib_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned LOCAL_COUNT = LOCAL_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  jib_in_if.sink         in_i,
  jib_out_if.source      out_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LAW = $clog2(LOCAL_COUNT);

  logic                       s1_valid_q;
  logic [FUNC_W-1:0]          s1_func_q;
  logic [INDEX_W-1:0]         s1_index_q;
  logic signed [IMM_W-1:0]    s1_imm_q;
  logic signed [OFFSET_W-1:0] s1_offset_q;
  logic [PC_W-1:0]            s1_pc_q;

  logic                       out_valid_q;
  exec_res_t                  out_res_q;
  logic [WORD_W-1:0]          out_top_q;
  logic [COUNT_W-1:0]         out_count_q;

  logic                       in_take;
  logic                       s1_move;
  logic [LAW-1:0]             rd_addr;
  logic [WORD_W-1:0]          local_word;
  logic [WORD_W-1:0]          tos;
  logic [WORD_W-1:0]          nos;
  logic [SPW-1:0]             count;
  logic [WORD_W-1:0]          top_nx;
  logic [SPW-1:0]             count_nx;
  stk_cmd_t                   stk_cmd;
  lv_wr_t                     lv_wr;
  exec_res_t                  res;

  // handshake
  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_take    = in_i.valid && in_i.ready;

  // local-file read address: iinc names its entry, iload encodes it in the opcode
  assign rd_addr = (in_i.func == OP_IINC) ? in_i.local_index[LAW-1:0]
                                          : LAW'(in_i.func - OP_ILOAD_0);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_func_q   <= in_i.func;
      s1_index_q  <= in_i.local_index;
      s1_imm_q    <= in_i.immediate;
      s1_offset_q <= in_i.branch_offset;
      s1_pc_q     <= in_i.pc;
    end
  end

  jib_locals #(
    .LOCAL_COUNT (LOCAL_COUNT)
  ) u_locals (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_take),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s1_move && lv_wr.en),
    .wr_addr_i (lv_wr.addr[LAW-1:0]),
    .wr_data_i (lv_wr.data),
    .rd_data_o (local_word)
  );

  jib_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (s1_move),
    .cmd_i      (stk_cmd),
    .tos_o      (tos),
    .nos_o      (nos),
    .count_o    (count),
    .top_nx_o   (top_nx),
    .count_nx_o (count_nx)
  );

  jib_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOCAL_COUNT (LOCAL_COUNT)
  ) u_exec (
    .func_i          (s1_func_q),
    .local_index_i   (s1_index_q),
    .immediate_i     (s1_imm_q),
    .branch_offset_i (s1_offset_q),
    .pc_i            (s1_pc_q),
    .tos_i           (tos),
    .nos_i           (nos),
    .count_i         (count),
    .local_i         (local_word),
    .stk_cmd_o       (stk_cmd),
    .lv_wr_o         (lv_wr),
    .res_o           (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_res_q   <= res;
      out_top_q   <= (count_nx == '0) ? '0 : top_nx;
      out_count_q <= COUNT_W'(count_nx);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.next_pc      = out_res_q.next_pc;
  assign out_o.branch_taken = out_res_q.branch_taken;
  assign out_o.halted       = out_res_q.halted;
  assign out_o.status       = out_res_q.status;
  assign out_o.top_value    = out_top_q;
  assign out_o.stack_count  = out_count_q;

endmodule

// File: hdl/jib_ram.sv
// generic single-port-write ram with registered read
module jib_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/jib_locals.sv
// local-variable file: ram, per-entry valid bits and write forwarding
module jib_locals import jib_pkg::*; #(
  parameter int unsigned LOCAL_COUNT = LOCAL_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [$clog2(LOCAL_COUNT)-1:0] rd_addr_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(LOCAL_COUNT)-1:0] wr_addr_i,
  input  logic [WORD_W-1:0]              wr_data_i,
  output logic [WORD_W-1:0]              rd_data_o
);

  logic [LOCAL_COUNT-1:0] valid_q;
  logic                   fwd_q;
  logic                   vld_q;
  logic [WORD_W-1:0]      fwd_data_q;
  logic [WORD_W-1:0]      ram_rdata;
  logic                   hit;

  jib_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LOCAL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // a read in the same cycle as a write to the same entry sees the new word
  assign hit = wr_en_i && (wr_addr_i == rd_addr_i);

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // read-side flags captured with the ram read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      vld_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= hit;
      vld_q <= valid_q[rd_addr_i];
    end
  end

  // forwarded word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (vld_q ? ram_rdata : '0);

endmodule

// File: hdl/jib_stack.sv
// operand stack as a shift line of registers, top entry at position zero
module jib_stack import jib_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  stk_cmd_t                           cmd_i,
  output logic [WORD_W-1:0]                  tos_o,
  output logic [WORD_W-1:0]                  nos_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count_o,
  output logic [WORD_W-1:0]                  top_nx_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count_nx_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] stk_q [STACK_DEPTH];
  logic [WORD_W-1:0] stk_d [STACK_DEPTH];
  logic [SPW-1:0]    sp_q;
  logic [SPW-1:0]    sp_d;

  // next value of each entry from its fixed neighbours
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_entry
    logic [WORD_W-1:0] up1;
    logic [WORD_W-1:0] up2;
    logic [WORD_W-1:0] dn1;

    if (g + 1 < STACK_DEPTH) begin : g_up1
      assign up1 = stk_q[g+1];
    end else begin : g_up1_end
      assign up1 = stk_q[g];
    end

    if (g + 2 < STACK_DEPTH) begin : g_up2
      assign up2 = stk_q[g+2];
    end else begin : g_up2_end
      assign up2 = stk_q[g];
    end

    if (g > 0) begin : g_dn1
      assign dn1 = stk_q[g-1];
    end else begin : g_dn1_top
      assign dn1 = cmd_i.value;
    end

    always_comb begin
      stk_d[g] = stk_q[g];
      if (en_i) begin
        case (cmd_i.op)
          SOP_PUSH:       stk_d[g] = dn1;
          SOP_POP1:       stk_d[g] = up1;
          SOP_POP2_PUSH1: stk_d[g] = (g == 0) ? cmd_i.value : up1;
          SOP_POP2:       stk_d[g] = up2;
          default:        stk_d[g] = stk_q[g];
        endcase
      end
    end

    always_ff @(posedge clk_i) begin
      stk_q[g] <= stk_d[g];
    end
  end

  // entry count
  always_comb begin
    sp_d = sp_q;
    if (en_i) begin
      case (cmd_i.op)
        SOP_PUSH:       sp_d = sp_q + SPW'(1);
        SOP_POP1:       sp_d = sp_q - SPW'(1);
        SOP_POP2_PUSH1: sp_d = sp_q - SPW'(1);
        SOP_POP2:       sp_d = sp_q - SPW'(2);
        default:        sp_d = sp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  assign tos_o      = stk_q[0];
  assign nos_o      = stk_q[1];
  assign count_o    = sp_q;
  assign top_nx_o   = stk_d[0];
  assign count_nx_o = sp_d;

endmodule

// File: hdl/jib_exec.sv
// decode and execute of one bytecode against the stack top and a local word
module jib_exec import jib_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned LOCAL_COUNT = LOCAL_COUNT_DEF
) (
  input  logic [FUNC_W-1:0]                func_i,
  input  logic [INDEX_W-1:0]               local_index_i,
  input  logic signed [IMM_W-1:0]          immediate_i,
  input  logic signed [OFFSET_W-1:0]       branch_offset_i,
  input  logic [PC_W-1:0]                  pc_i,
  input  logic [WORD_W-1:0]                tos_i,
  input  logic [WORD_W-1:0]                nos_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0] count_i,
  input  logic [WORD_W-1:0]                local_i,
  output stk_cmd_t                         stk_cmd_o,
  output lv_wr_t                           lv_wr_o,
  output exec_res_t                        res_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] imm_ext;
  logic [WORD_W-1:0] alu_r;
  logic [WORD_W-1:0] mul_r;
  logic [PC_W-1:0]   len;
  logic              taken;
  logic              empty;
  logic              below_two;
  logic              full;
  logic              idx_bad;

  assign imm_ext   = WORD_W'(immediate_i);
  assign empty     = (count_i == '0);
  assign below_two = (count_i < SPW'(2));
  assign full      = (count_i >= SPW'(STACK_DEPTH));
  assign idx_bad   = ({1'b0, local_index_i} >= (INDEX_W + 1)'(LOCAL_COUNT));
  assign mul_r     = nos_i * tos_i;

  // binary arithmetic, deeper operand first
  always_comb begin
    case (func_i)
      OP_IADD: alu_r = nos_i + tos_i;
      OP_ISUB: alu_r = nos_i - tos_i;
      OP_IMUL: alu_r = mul_r;
      OP_ISHL: alu_r = nos_i << tos_i[4:0];
      default: alu_r = WORD_W'($signed(nos_i) >>> tos_i[4:0]);
    endcase
  end

  // opcode decode
  always_comb begin
    stk_cmd_o.op    = SOP_NONE;
    stk_cmd_o.value = '0;
    lv_wr_o.en      = 1'b0;
    lv_wr_o.addr    = '0;
    lv_wr_o.data    = tos_i;
    res_o.halted    = 1'b0;
    res_o.status    = ST_OK;
    len             = LEN_SHORT;
    taken           = 1'b0;

    if (func_i >= OP_ICONST_NEG && func_i <= OP_ICONST_5) begin
      stk_cmd_o.value = {{(WORD_W-FUNC_W){1'b0}}, func_i} - ICONST_BIAS;
      if (full) res_o.status = ST_OVERFLOW;
      else      stk_cmd_o.op = SOP_PUSH;
    end else if (func_i == OP_BIPUSH) begin
      len             = LEN_BYTE;
      stk_cmd_o.value = imm_ext;
      if (full) res_o.status = ST_OVERFLOW;
      else      stk_cmd_o.op = SOP_PUSH;
    end else if (func_i >= OP_ILOAD_0 && func_i <= OP_ILOAD_3) begin
      stk_cmd_o.value = local_i;
      if (full) res_o.status = ST_OVERFLOW;
      else      stk_cmd_o.op = SOP_PUSH;
    end else if (func_i >= OP_ISTORE_0 && func_i <= OP_ISTORE_3) begin
      lv_wr_o.addr = func_i - OP_ISTORE_0;
      if (empty) begin
        res_o.status = ST_UNDERFLOW;
      end else begin
        stk_cmd_o.op = SOP_POP1;
        lv_wr_o.en   = 1'b1;
      end
    end else if (func_i == OP_IADD || func_i == OP_ISUB || func_i == OP_IMUL ||
                 func_i == OP_ISHL || func_i == OP_ISHR) begin
      stk_cmd_o.value = alu_r;
      if (below_two) res_o.status = ST_UNDERFLOW;
      else           stk_cmd_o.op = SOP_POP2_PUSH1;
    end else if (func_i == OP_IINC) begin
      len          = LEN_WIDE;
      lv_wr_o.addr = local_index_i;
      lv_wr_o.data = local_i + imm_ext;
      if (idx_bad) res_o.status = ST_BAD_LOCAL;
      else         lv_wr_o.en   = 1'b1;
    end else if (func_i >= OP_IFEQ && func_i <= OP_IFLE) begin
      len = LEN_WIDE;
      if (empty) begin
        res_o.status = ST_UNDERFLOW;
      end else begin
        stk_cmd_o.op = SOP_POP1;
        taken        = cmp_f(CMP_W'(func_i - OP_IFEQ), tos_i, '0);
      end
    end else if (func_i >= OP_IF_ICMPEQ && func_i <= OP_IF_ICMPLE) begin
      len = LEN_WIDE;
      if (below_two) begin
        res_o.status = ST_UNDERFLOW;
      end else begin
        stk_cmd_o.op = SOP_POP2;
        taken        = cmp_f(CMP_W'(func_i - OP_IF_ICMPEQ), nos_i, tos_i);
      end
    end else if (func_i == OP_GOTO) begin
      len   = LEN_WIDE;
      taken = 1'b1;
    end else if (func_i == OP_IRETURN || func_i == OP_RETURN) begin
      res_o.halted = 1'b1;
    end else if (func_i == OP_GETSTATIC) begin
      len = LEN_WIDE;
    end
  end

  // next pc, wraps at the top of the address space
  assign res_o.branch_taken = taken;
  assign res_o.next_pc      = taken ? (pc_i + PC_W'(unsigned'(branch_offset_i)))
                                    : (pc_i + len);

endmodule
